// ----- hw/rtl/brsc_pkg.sv -----
// Package for the bivariate risk-set counter: sizes, codes, payload types
// and the sample conversion function. No dependencies.
package brsc_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int SAMPLE_BITS = 32;
    localparam int IN_BITS     = 32;
    localparam int INDEX_BITS  = 8;
    localparam int COUNT_W     = 9;
    localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QTHR   = 2'd2,
        OP_QIDX   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_THR,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [IN_BITS-1:0]  x_value;
        logic signed [IN_BITS-1:0]  y_value;
        logic [INDEX_BITS-1:0]      row_index;
        logic [INDEX_BITS-1:0]      col_index;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        status_t            status;
    } out_item_t;

    // Sign-extend or truncate an input word to the sample width.
    function automatic sample_t to_sample(input logic signed [IN_BITS-1:0] v);
        return SAMPLE_BITS'(v);
    endfunction

endpackage

// ----- hw/rtl/bivariate_risk_set_counter_unit.sv -----
// Top level of the bivariate risk-set counter: sequencer, shared comparator
// and counter. Depends on brsc_pkg and brsc_ram.
//
// Usage:
//   Input transactions arrive on s_valid/s_ready/s_data (brsc_pkg::in_item_t),
//   results leave on m_valid/m_ready/m_data (brsc_pkg::out_item_t), one result
//   per input transaction, in order.
//   Clear and append: the result is registered, then moved to the output
//   register once it is free. Threshold query: scans the stored points;
//   an empty set skips the scan. Index query: reads the two indexed points
//   as thresholds, then scans; an index out of range skips the scan.
//   Query time is set by the scan, which reads one stored point per cycle
//   from the x and y RAMs through one comparator pair and one counter. s_ready
//   is high only in idle, which follows each result's move to the output.
//   A finished result waits in the output register; the next transaction is
//   accepted while it waits, and the sequencer holds its own next result
//   until the receiver takes the previous one.
//   Reset (aresetn low, synchronous) empties the set and drops any pending
//   result; the point RAMs are not cleared and need no clearing pass.
module bivariate_risk_set_counter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  brsc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output brsc_pkg::out_item_t m_data
);

    brsc_pkg::state_t            state_reg, state_next;
    logic [brsc_pkg::CNT_W-1:0]  stored_reg, stored_next;
    logic [brsc_pkg::CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [brsc_pkg::CNT_W-1:0]  hit_reg, hit_next;
    logic                        pend_reg, pend_next;
    brsc_pkg::sample_t           thr_x_reg, thr_x_next;
    brsc_pkg::sample_t           thr_y_reg, thr_y_next;
    brsc_pkg::out_item_t         res_reg, res_next;
    brsc_pkg::out_item_t         out_reg, out_next;
    logic                        out_vld_reg, out_vld_next;

    logic                                wr_en;
    logic [brsc_pkg::IDX_W-1:0]          wr_addr;
    logic [brsc_pkg::IDX_W-1:0]          rx_addr, ry_addr;
    logic [brsc_pkg::SAMPLE_BITS-1:0]    rx_data, ry_data;
    logic                                accept, out_free, row_bad, col_bad, hit;
    logic [brsc_pkg::CNT_W+brsc_pkg::INDEX_BITS-1:0] row_ext, col_ext, stored_ext;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_vld_reg || m_ready;
    assign s_ready  = (state_reg == brsc_pkg::ST_IDLE);
    assign m_valid  = out_vld_reg;
    assign m_data   = out_reg;

    assign row_ext    = (brsc_pkg::CNT_W + brsc_pkg::INDEX_BITS)'(s_data.row_index);
    assign col_ext    = (brsc_pkg::CNT_W + brsc_pkg::INDEX_BITS)'(s_data.col_index);
    assign stored_ext = (brsc_pkg::CNT_W + brsc_pkg::INDEX_BITS)'(stored_reg);
    assign row_bad    = (row_ext >= stored_ext);
    assign col_bad    = (col_ext >= stored_ext);

    assign hit = (brsc_pkg::sample_t'(rx_data) >= thr_x_reg) &&
                 (brsc_pkg::sample_t'(ry_data) >= thr_y_reg);

    assign wr_en   = accept && (s_data.opcode == brsc_pkg::OP_APPEND) &&
                     (stored_reg < brsc_pkg::CNT_W'(brsc_pkg::MAX_POINTS));
    assign wr_addr = stored_reg[brsc_pkg::IDX_W-1:0];

    always_comb begin
        if (state_reg == brsc_pkg::ST_IDLE) begin
            rx_addr = brsc_pkg::IDX_W'(s_data.row_index);
            ry_addr = brsc_pkg::IDX_W'(s_data.col_index);
        end else begin
            rx_addr = rd_cnt_reg[brsc_pkg::IDX_W-1:0];
            ry_addr = rd_cnt_reg[brsc_pkg::IDX_W-1:0];
        end
    end

    brsc_ram #(
        .WIDTH (brsc_pkg::SAMPLE_BITS),
        .DEPTH (brsc_pkg::MAX_POINTS)
    ) u_x_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (brsc_pkg::to_sample(s_data.x_value)),
        .raddr (rx_addr),
        .rdata (rx_data)
    );

    brsc_ram #(
        .WIDTH (brsc_pkg::SAMPLE_BITS),
        .DEPTH (brsc_pkg::MAX_POINTS)
    ) u_y_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (brsc_pkg::to_sample(s_data.y_value)),
        .raddr (ry_addr),
        .rdata (ry_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= brsc_pkg::ST_IDLE;
            stored_reg  <= '0;
            out_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stored_reg  <= stored_next;
            out_vld_reg <= out_vld_next;
            pend_reg    <= pend_next;
        end
        rd_cnt_reg <= rd_cnt_next;
        hit_reg    <= hit_next;
        thr_x_reg  <= thr_x_next;
        thr_y_reg  <= thr_y_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        stored_next  = stored_reg;
        rd_cnt_next  = rd_cnt_reg;
        hit_next     = hit_reg;
        pend_next    = 1'b0;
        thr_x_next   = thr_x_reg;
        thr_y_next   = thr_y_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_ready;

        unique case (state_reg)
            brsc_pkg::ST_IDLE: begin
                if (accept) begin
                    res_next.status = brsc_pkg::STATUS_OK;
                    res_next.count  = '0;
                    rd_cnt_next     = '0;
                    hit_next        = '0;
                    thr_x_next      = brsc_pkg::to_sample(s_data.x_value);
                    thr_y_next      = brsc_pkg::to_sample(s_data.y_value);
                    state_next      = brsc_pkg::ST_FIN;
                    unique case (s_data.opcode)
                        brsc_pkg::OP_CLEAR: begin
                            stored_next = '0;
                        end
                        brsc_pkg::OP_APPEND: begin
                            if (wr_en) begin
                                stored_next    = stored_reg + 1'b1;
                                res_next.count = brsc_pkg::COUNT_W'(stored_reg + 1'b1);
                            end else begin
                                res_next.count  = brsc_pkg::COUNT_W'(stored_reg);
                                res_next.status = brsc_pkg::STATUS_FULL;
                            end
                        end
                        brsc_pkg::OP_QTHR: begin
                            if (stored_reg != '0) begin
                                state_next = brsc_pkg::ST_SCAN;
                            end
                        end
                        brsc_pkg::OP_QIDX: begin
                            if (row_bad || col_bad) begin
                                res_next.status = brsc_pkg::STATUS_RANGE;
                            end else begin
                                state_next = brsc_pkg::ST_THR;
                            end
                        end
                        default: begin
                            state_next = brsc_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            brsc_pkg::ST_THR: begin
                thr_x_next = brsc_pkg::sample_t'(rx_data);
                thr_y_next = brsc_pkg::sample_t'(ry_data);
                state_next = brsc_pkg::ST_SCAN;
            end
            brsc_pkg::ST_SCAN: begin
                if (rd_cnt_reg < stored_reg) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (pend_reg && hit) begin
                    hit_next = hit_reg + 1'b1;
                end
                if (!pend_reg && (rd_cnt_reg >= stored_reg)) begin
                    res_next.count = brsc_pkg::COUNT_W'(hit_reg);
                    state_next     = brsc_pkg::ST_FIN;
                end
            end
            brsc_pkg::ST_FIN: begin
                if (out_free) begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = brsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brsc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_stored_max: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= brsc_pkg::CNT_W'(brsc_pkg::MAX_POINTS))
        else $error("stored point count beyond capacity");

    a_hits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == brsc_pkg::ST_SCAN) |-> (hit_reg <= rd_cnt_reg))
        else $error("hit count exceeds points scanned");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == brsc_pkg::STATUS_RANGE)) |-> (m_data.count == '0))
        else $error("out-of-range index with nonzero count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while busy");
`endif

endmodule

// ----- hw/rtl/brsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/brsc_risk_set_checker.sv -----
`timescale 1ns / 100ps
// Checker for the bivariate risk-set counter: watches both channels, predicts
// each result from its own copy of the point set and compares in order.
// Depends on brsc_pkg.
module brsc_risk_set_checker
    import brsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        outstanding
);

    sample_t   pt_x [MAX_POINTS];
    sample_t   pt_y [MAX_POINTS];
    int        pt_fill = 0;
    out_item_t expected_q [$];
    int        mismatches = 0;

    assign fail_count = mismatches;

    function automatic int dominance_count(sample_t a, sample_t b);
        int n;
        n = 0;
        for (int i = 0; i < pt_fill; i++) begin
            if (pt_x[i] >= a && pt_y[i] >= b) n++;
        end
        return n;
    endfunction

    function automatic out_item_t predict_risk_set(in_item_t t);
        out_item_t r;
        sample_t   a;
        sample_t   b;
        a = t.x_value;
        b = t.y_value;
        r.count  = '0;
        r.status = STATUS_OK;
        case (t.opcode)
            OP_CLEAR: begin
                pt_fill = 0;
            end
            OP_APPEND: begin
                if (pt_fill >= MAX_POINTS) begin
                    r.status = STATUS_FULL;
                end else begin
                    pt_x[pt_fill] = a;
                    pt_y[pt_fill] = b;
                    pt_fill++;
                end
                r.count = COUNT_W'(pt_fill);
            end
            OP_QTHR: begin
                r.count = COUNT_W'(dominance_count(a, b));
            end
            default: begin
                if (int'(t.row_index) >= pt_fill || int'(t.col_index) >= pt_fill) begin
                    r.status = STATUS_RANGE;
                end else begin
                    r.count = COUNT_W'(dominance_count(pt_x[t.row_index],
                                                       pt_y[t.col_index]));
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected count=%0d status=%0d, got count=%0d status=%0d",
                     $realtime, what, want.count, want.status, got.count, got.status);
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            expected_q.delete();
            pt_fill = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    want = '0;
                    flag_mismatch("unexpected result transaction", want, m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.count !== want.count || m_data.status !== want.status)
                        flag_mismatch("result mismatch", want, m_data);
                end
            end
            if (s_valid && s_ready) expected_q.push_back(predict_risk_set(s_data));
        end
        outstanding <= expected_q.size();
    end

endmodule

// ----- tb/bivariate_risk_set_counter_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the bivariate risk-set counter testbench: clock, reset, stimulus,
// receiver back-pressure and verdict. Depends on brsc_pkg, the block and
// brsc_risk_set_checker.
module bivariate_risk_set_counter_unit_tb;
    import brsc_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic signed [IN_BITS-1:0] S_MIN = {1'b1, {(IN_BITS-1){1'b0}}};
    localparam logic signed [IN_BITS-1:0] S_MAX = {1'b0, {(IN_BITS-1){1'b1}}};

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_count;
    int outstanding;
    int cycles     = 0;
    int items_sent = 0;
    int fill       = 0;
    int burst_left = 0;
    bit drained_mid = 1'b0;

    int taken_in   = 0;
    int hold_left  = 0;
    int phase_left = 0;
    int rx_mode    = 0;
    bit hold_done  = 1'b0;

    always #5 aclk = ~aclk;

    bivariate_risk_set_counter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    brsc_risk_set_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: phases of free flow, random and heavy stalling; one long hold-off
    always @(posedge aclk) begin
        if (s_valid && s_ready) taken_in <= taken_in + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_in >= 400) begin
            hold_done <= 1'b1;
            hold_left <= 500;
            m_ready   <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 300);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic in_item_t mk(input opcode_t op,
                                    input logic signed [IN_BITS-1:0] x,
                                    input logic signed [IN_BITS-1:0] y,
                                    input logic [INDEX_BITS-1:0] r,
                                    input logic [INDEX_BITS-1:0] c);
        in_item_t t;
        t.opcode    = op;
        t.x_value   = x;
        t.y_value   = y;
        t.row_index = r;
        t.col_index = c;
        return t;
    endfunction

    function automatic logic signed [IN_BITS-1:0] junk_word();
        return IN_BITS'($urandom);
    endfunction

    function automatic logic [INDEX_BITS-1:0] junk_index();
        return INDEX_BITS'($urandom);
    endfunction

    // narrow samples give ties, so the inclusive compares get exercised
    function automatic logic signed [IN_BITS-1:0] pick_sample(input bit narrow);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return S_MIN;
        if (pick == 1) return S_MAX;
        if (narrow || pick < 4) return IN_BITS'($urandom_range(0, 16)) - IN_BITS'(8);
        return junk_word();
    endfunction

    function automatic in_item_t noise_item();
        return mk(opcode_t'($urandom_range(0, 3)), junk_word(), junk_word(),
                  junk_index(), junk_index());
    endfunction

    task automatic send_item(input in_item_t t);
        int gap;
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        case (t.opcode)
            OP_CLEAR:  fill = 0;
            OP_APPEND: if (fill < MAX_POINTS) fill++;
            default:   ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic run_episode(input bit force_full);
        int n;
        int q;
        int pick;
        int r;
        int c;
        bit narrow;
        narrow = $urandom_range(0, 1);
        pick   = $urandom_range(0, 99);
        if (force_full || pick < 5)  n = MAX_POINTS + $urandom_range(1, 4);
        else if (pick < 20)          n = $urandom_range(25, 100);
        else                         n = $urandom_range(1, 24);
        if (force_full || fill > 150 || $urandom_range(0, 4) != 0)
            send_item(mk(OP_CLEAR, junk_word(), junk_word(), junk_index(), junk_index()));
        for (int i = 0; i < n; i++) begin
            if (!force_full && $urandom_range(0, 19) == 0) send_item(noise_item());
            send_item(mk(OP_APPEND, pick_sample(narrow), pick_sample(narrow),
                         junk_index(), junk_index()));
        end
        q = $urandom_range(1, 12);
        for (int i = 0; i < q; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || fill == 0) begin
                send_item(mk(OP_QTHR, pick_sample(narrow), pick_sample(narrow),
                             junk_index(), junk_index()));
            end else if (pick < 85 || fill == MAX_POINTS) begin
                r = $urandom_range(0, fill - 1);
                c = $urandom_range(0, fill - 1);
                send_item(mk(OP_QIDX, junk_word(), junk_word(),
                             INDEX_BITS'(r), INDEX_BITS'(c)));
            end else if (pick < 95) begin
                r = $urandom_range(0, fill - 1);
                c = $urandom_range(0, fill - 1);
                if ($urandom_range(0, 1)) r = $urandom_range(fill, 255);
                else                      c = $urandom_range(fill, 255);
                send_item(mk(OP_QIDX, junk_word(), junk_word(),
                             INDEX_BITS'(r), INDEX_BITS'(c)));
            end else begin
                send_item(noise_item());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty set
        send_item(mk(OP_QTHR, S_MIN, S_MIN, junk_index(), junk_index()));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd0, 8'd0));
        // extremes and duplicates
        send_item(mk(OP_APPEND, S_MIN, S_MIN, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, S_MAX, S_MAX, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, '0, '0, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, -1, S_MAX, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, S_MAX, -1, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, '0, '0, junk_index(), junk_index()));
        send_item(mk(OP_QTHR, S_MIN, S_MIN, junk_index(), junk_index()));
        send_item(mk(OP_QTHR, S_MAX, S_MAX, junk_index(), junk_index()));
        send_item(mk(OP_QTHR, '0, '0, junk_index(), junk_index()));
        send_item(mk(OP_QTHR, -1, -1, junk_index(), junk_index()));
        send_item(mk(OP_QTHR, S_MAX, S_MIN, junk_index(), junk_index()));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd0, 8'd0));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd5, 8'd5));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd1, 8'd2));
        // indices out of range
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd6, 8'd0));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd0, 8'd255));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd255, 8'd255));
        // clear with rubbish in the unused fields
        send_item(mk(OP_CLEAR, junk_word(), junk_word(), junk_index(), junk_index()));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd0, 8'd0));
        send_item(mk(OP_QTHR, S_MIN, S_MIN, junk_index(), junk_index()));
        send_item(mk(OP_APPEND, 32'sd1, 32'sd2, junk_index(), junk_index()));
        send_item(mk(OP_QIDX, junk_word(), junk_word(), 8'd0, 8'd0));

        // full store first, then mixed transactions
        run_episode(1'b1);
        while (items_sent < ITEM_TARGET) begin
            if (!drained_mid && items_sent >= 900) begin
                drain();
                drained_mid = 1'b1;
            end
            run_episode(1'b0);
        end

        drain();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/brsc_pkg.sv
hw/rtl/brsc_ram.sv
hw/rtl/bivariate_risk_set_counter_unit.sv
tb/brsc_risk_set_checker.sv
tb/bivariate_risk_set_counter_unit_tb.sv
